### src/cfwc_pkg.sv
// ============================================================================
// cfwc_pkg: shared types and constants of the CID fragment whitening codec
// Keystream mixing constants, header layout, status codes and the
// controller-to-datapath command bundle.
// ============================================================================
package cfwc_pkg;

    localparam int unsigned POS_W      = 5;
    localparam int unsigned LEN_W      = POS_W + 1;
    localparam int unsigned MAX_ID_LEN = 20;
    localparam int unsigned HEADER_LEN = 8;

    // header positions inside the plaintext identifier
    localparam logic [POS_W-1:0] POS_INDEX  = 5'd5;
    localparam logic [POS_W-1:0] POS_TOTAL  = 5'd6;
    localparam logic [POS_W-1:0] POS_LENGTH = 5'd7;
    localparam logic [POS_W-1:0] POS_MAX    = 5'd31;

    // keystream mix constants
    localparam logic [31:0] KS_BASE  = 32'h9E3779B9;
    localparam logic [31:0] KS_STEP  = 32'h045D9F3B;
    localparam logic [31:0] KS_MUL_A = 32'h7FEB352D;
    localparam logic [31:0] KS_MUL_B = 32'h846CA68B;

    // end-of-identifier status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_BAD_FRAG = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic load;   // take a new input beat
        logic mul;    // first mix multiply
        logic fin;    // second mix multiply, load output register
    } t_cmd;

    // position scaled by the step constant, narrow operand times constant
    function automatic logic [31:0] pos_scale(input logic [POS_W-1:0] pos);
        logic [31:0] prod;
        prod = 32'(pos) * KS_STEP;
        return prod;
    endfunction

endpackage

### src/cfwc_ctrl.sv
// ============================================================================
// cfwc_ctrl: sequencing controller
// Steps each accepted beat through the multiply states S_MUL1 and S_MUL2 of the mix unit
// and owns the output valid flag.
// ============================================================================
module cfwc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output cfwc_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       w_out_free;
    logic       w_fin;
    logic       w_in_rdy;
    logic       w_load;

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_fin      = (r_state == S_MUL2) && w_out_free;
    // a new beat may enter while the finishing one moves to the output
    assign w_in_rdy   = (r_state == S_IDLE) || w_fin;
    assign w_load     = i_valid && w_in_rdy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load) n_state = S_MUL1;
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                if (w_fin) n_state = w_load ? S_MUL1 : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_fin) begin
            n_out_vld = 1'b1;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall    = !w_in_rdy;
    assign o_valid    = r_out_vld;
    assign o_cmd.load = w_load;
    assign o_cmd.mul  = (r_state == S_MUL1);
    assign o_cmd.fin  = w_fin;

endmodule

### src/cfwc_dpath.sv
// ============================================================================
// cfwc_dpath: whitening datapath
// Identifier state, keystream mix unit, header capture, status check and
// the output register.
// ============================================================================
module cfwc_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfwc_pkg::t_cmd               i_cmd,
    input  logic                         i_cfg_we,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         i_func,
    input  logic [7:0]                   i_data_byte,
    input  logic [7:0]                   i_nonce_in,
    input  logic                         i_last_byte,
    output logic [7:0]                   o_out_byte,
    output logic [cfwc_pkg::POS_W-1:0]   o_byte_pos,
    output logic                         o_end_flag,
    output logic [1:0]                   o_status
);

    localparam int unsigned PW = cfwc_pkg::POS_W;
    localparam int unsigned LW = cfwc_pkg::LEN_W;

    // identifier state
    logic [7:0]    r_marker;
    logic          r_mode;
    logic [7:0]    r_nonce, n_nonce;
    logic [PW-1:0] r_pos_cnt, n_pos_cnt;
    logic [7:0]    r_index, n_index;
    logic [7:0]    r_total, n_total;
    logic [7:0]    r_length, n_length;

    // beat in flight
    logic [PW-1:0] r_it_pos;
    logic [7:0]    r_it_data;
    logic          r_it_last;
    logic [31:0]   r_x;

    // output register
    logic [7:0]    r_out_byte;
    logic [PW-1:0] r_out_pos;
    logic          r_out_end;
    logic [1:0]    r_out_status;

    logic          w_first;
    logic [31:0]   w_seed;
    logic [31:0]   w_m1;
    logic [31:0]   w_m2;
    logic [31:0]   w_y;
    logic [7:0]    w_ks;
    logic          w_zero;
    logic [7:0]    w_plain;
    logic [7:0]    w_res;
    logic [LW-1:0] w_len;
    logic [LW-1:0] w_min_len;
    logic [1:0]    w_status;

    // ---------------- accept: state update and mix seed ----------------
    assign w_first = (r_pos_cnt == '0);
    assign w_seed  = {r_nonce, 24'd0} ^ (cfwc_pkg::KS_BASE + cfwc_pkg::pos_scale(r_pos_cnt));

    always_comb begin
        n_nonce = r_nonce;
        if (w_first) begin
            n_nonce = i_func ? (i_data_byte ^ r_marker) : i_nonce_in;
        end
        if (i_last_byte) begin
            n_pos_cnt = '0;
        end else if (r_pos_cnt != cfwc_pkg::POS_MAX) begin
            n_pos_cnt = r_pos_cnt + PW'(1);
        end else begin
            n_pos_cnt = r_pos_cnt;
        end
    end

    // ---------------- mix multiplies ----------------
    assign w_m1 = r_x * cfwc_pkg::KS_MUL_A;
    assign w_m2 = r_x * cfwc_pkg::KS_MUL_B;
    assign w_y  = w_m2 ^ (w_m2 >> 16);
    assign w_ks = w_y[7:0];

    // ---------------- finish: result, header capture, status ----------------
    always_comb begin
        w_zero  = (r_it_pos >= PW'(cfwc_pkg::HEADER_LEN)) &&
                  ({3'd0, r_it_pos - PW'(cfwc_pkg::HEADER_LEN)} >= r_length);
        if (r_mode) begin
            w_plain = r_it_data ^ w_ks;
            w_res   = w_plain;
        end else begin
            w_plain = w_zero ? 8'd0 : r_it_data;
            w_res   = w_plain ^ w_ks;
        end
        if (r_it_pos == '0) w_res = r_it_data;

        n_index  = r_index;
        n_total  = r_total;
        n_length = r_length;
        if (r_it_pos == '0) begin
            n_index  = 8'd0;
            n_total  = 8'd0;
            n_length = 8'd0;
        end else if (r_it_pos == cfwc_pkg::POS_INDEX) begin
            n_index = w_plain;
        end else if (r_it_pos == cfwc_pkg::POS_TOTAL) begin
            n_total = w_plain;
        end else if (r_it_pos == cfwc_pkg::POS_LENGTH) begin
            n_length = w_plain;
        end
    end

    always_comb begin
        w_len     = {1'b0, r_it_pos} + LW'(1);
        w_min_len = r_mode ? LW'(cfwc_pkg::HEADER_LEN) : LW'(cfwc_pkg::HEADER_LEN + 1);
        w_status  = cfwc_pkg::ST_OK;
        if (r_it_last) begin
            if ((w_len < w_min_len) || (w_len > LW'(cfwc_pkg::MAX_ID_LEN))) begin
                w_status = cfwc_pkg::ST_BAD_LEN;
            end else if ((n_total == 8'd0) || (n_index >= n_total)) begin
                w_status = cfwc_pkg::ST_BAD_FRAG;
            end else if (n_length > {2'd0, w_len - LW'(cfwc_pkg::HEADER_LEN)}) begin
                w_status = cfwc_pkg::ST_TOO_LONG;
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker  <= 8'd0;
            r_mode    <= 1'b0;
            r_nonce   <= 8'd0;
            r_pos_cnt <= '0;
            r_index   <= 8'd0;
            r_total   <= 8'd0;
            r_length  <= 8'd0;
        end else begin
            if (i_cfg_we) r_marker <= i_cfg_data;
            if (i_cmd.load) begin
                if (w_first) r_mode <= i_func;
                r_nonce   <= n_nonce;
                r_pos_cnt <= n_pos_cnt;
            end
            if (i_cmd.fin) begin
                r_index  <= n_index;
                r_total  <= n_total;
                r_length <= n_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_it_pos  <= r_pos_cnt;
            r_it_last <= i_last_byte;
            r_x       <= w_seed ^ (w_seed >> 16);
            // byte 0 carries its finished value straight through
            if (w_first) begin
                r_it_data <= i_func ? r_marker : (i_nonce_in ^ r_marker);
            end else begin
                r_it_data <= i_data_byte;
            end
        end else if (i_cmd.mul) begin
            r_x <= w_m1 ^ (w_m1 >> 15);
        end
        if (i_cmd.fin) begin
            r_out_byte   <= w_res;
            r_out_pos    <= r_it_pos;
            r_out_end    <= r_it_last;
            r_out_status <= w_status;
        end
    end

    assign o_out_byte = r_out_byte;
    assign o_byte_pos = r_out_pos;
    assign o_end_flag = r_out_end;
    assign o_status   = r_out_status;

endmodule

### src/cid_fragment_whitening_codec_unit.sv
// Sequencing: an accepted beat loads the mix seed; S_MUL1 and S_MUL2 then run the
//   two chained 32-bit constant multiplies of the keystream mix unit, and S_MUL2 loads
//   the output register; the next beat enters as one finishes.
// A stalled output register holds the finished beat and the unit waits.
// Reset: synchronous, active low on i_rst_n; clears the sequencer, the marker
//   register and all identifier state, so the next beat is byte 0.
// ============================================================================
// cid_fragment_whitening_codec_unit: CID fragment whitening codec, top level
// Whitens or unwhitens connection identifier bytes one beat at a time and
// reports length and header faults on the last byte.
// ============================================================================
module cid_fragment_whitening_codec_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_func,
    input  logic [7:0]                 i_data_byte,
    input  logic [7:0]                 i_nonce_in,
    input  logic                       i_last_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_out_byte,
    output logic [cfwc_pkg::POS_W-1:0] o_byte_pos,
    output logic                       o_end_flag,
    output logic [1:0]                 o_status
);

    cfwc_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    cfwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    cfwc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_nonce_in  (i_nonce_in),
        .i_last_byte (i_last_byte),
        .o_out_byte  (o_out_byte),
        .o_byte_pos  (o_byte_pos),
        .o_end_flag  (o_end_flag),
        .o_status    (o_status)
    );

endmodule

### tb/tb_cid_fragment_whitening_codec_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_cid_fragment_whitening_codec_unit: self-checking bench of the CID codec
// Streams encode and decode identifiers (well formed, short, long, bad header)
// through the unit under random idling on both sides and across several marker
// settings, and checks every result beat against a cycle-free predictor.
// ============================================================================
module tb_cid_fragment_whitening_codec_unit;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;
    localparam int   IDLE_LIMIT  = 5000;
    localparam int   LONG_HOLD   = 80;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
        logic [7:0] nonce;
        logic       last;
    } t_cid_beat;

    typedef struct packed {
        logic [7:0]                 out_byte;
        logic [cfwc_pkg::POS_W-1:0] pos;
        logic                       last;
        logic [1:0]                 status;
    } t_cid_result;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [7:0]                 i_cfg_data  = 8'h00;
    logic                       i_valid     = 1'b0;
    logic                       i_func      = 1'b0;
    logic [7:0]                 i_data_byte = 8'h00;
    logic [7:0]                 i_nonce_in  = 8'h00;
    logic                       i_last_byte = 1'b0;
    logic                       i_stall     = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_stall;
    logic                       o_valid;
    logic [7:0]                 o_out_byte;
    logic [cfwc_pkg::POS_W-1:0] o_byte_pos;
    logic                       o_end_flag;
    logic [1:0]                 o_status;

    cid_fragment_whitening_codec_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_nonce_in  (i_nonce_in),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_byte_pos  (o_byte_pos),
        .o_end_flag  (o_end_flag),
        .o_status    (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bench state
    t_cid_beat   id_beats[$];
    t_cid_result codec_results[$];
    int          mismatch_count = 0;
    int          sender_gap_max = 0;
    int          stall_max      = 0;
    bit          long_hold_req  = 1'b0;

    // codec state as the unit should hold it
    logic [7:0]                 marker_model = 8'h00;
    logic                       id_mode      = FUNC_ENCODE;
    logic [7:0]                 id_nonce     = 8'h00;
    logic [cfwc_pkg::POS_W-1:0] id_pos       = '0;
    logic [7:0]                 hdr_index    = 8'h00;
    logic [7:0]                 hdr_total    = 8'h00;
    logic [7:0]                 hdr_length   = 8'h00;

    function automatic logic [7:0] whitening_pad(input logic [7:0] nonce,
                                                 input logic [cfwc_pkg::POS_W-1:0] pos);
        logic [31:0] x;
        x = {nonce, 24'h000000} ^ (cfwc_pkg::KS_BASE + 32'(pos) * cfwc_pkg::KS_STEP);
        x = x ^ (x >> 16);
        x = x * cfwc_pkg::KS_MUL_A;
        x = x ^ (x >> 15);
        x = x * cfwc_pkg::KS_MUL_B;
        x = x ^ (x >> 16);
        return x[7:0];
    endfunction

    // advance the codec state by one input beat and return its result beat
    function automatic t_cid_result codec_step(input t_cid_beat b);
        t_cid_result r;
        logic [cfwc_pkg::POS_W-1:0] p;
        logic [7:0] pad;
        logic [7:0] plain;
        int len;
        int min_len;
        p = id_pos;
        r.pos = p;
        r.last = b.last;
        r.status = cfwc_pkg::ST_OK;
        if (p == 0) begin
            id_mode = b.func;
            hdr_index = 8'h00;
            hdr_total = 8'h00;
            hdr_length = 8'h00;
            if (b.func == FUNC_ENCODE) begin
                id_nonce = b.nonce;
                r.out_byte = b.nonce ^ marker_model;
            end else begin
                id_nonce = b.data ^ marker_model;
                r.out_byte = marker_model;
            end
        end else begin
            pad = whitening_pad(id_nonce, p);
            if (id_mode == FUNC_ENCODE) begin
                plain = b.data;
                // payload past the data length goes out as zero plaintext
                if (int'(p) >= int'(cfwc_pkg::HEADER_LEN) &&
                    int'(p) - int'(cfwc_pkg::HEADER_LEN) >= int'(hdr_length))
                    plain = 8'h00;
                r.out_byte = plain ^ pad;
            end else begin
                plain = b.data ^ pad;
                r.out_byte = plain;
            end
            if (p == cfwc_pkg::POS_INDEX)
                hdr_index = plain;
            else if (p == cfwc_pkg::POS_TOTAL)
                hdr_total = plain;
            else if (p == cfwc_pkg::POS_LENGTH)
                hdr_length = plain;
        end
        if (b.last) begin
            len = int'(p) + 1;
            min_len = (id_mode == FUNC_ENCODE) ? int'(cfwc_pkg::HEADER_LEN) + 1
                                               : int'(cfwc_pkg::HEADER_LEN);
            if (len < min_len || len > int'(cfwc_pkg::MAX_ID_LEN))
                r.status = cfwc_pkg::ST_BAD_LEN;
            else if (hdr_total == 0 || hdr_index >= hdr_total)
                r.status = cfwc_pkg::ST_BAD_FRAG;
            else if (int'(hdr_length) > len - int'(cfwc_pkg::HEADER_LEN))
                r.status = cfwc_pkg::ST_TOO_LONG;
            id_pos = '0;
        end else if (p < cfwc_pkg::POS_MAX) begin
            id_pos = p + 1'b1;
        end
        return r;
    endfunction

    // driver: present queued beats, hold while stalled
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_cid_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall)
                codec_results.push_back(codec_step({i_func, i_data_byte, i_nonce_in,
                                                    i_last_byte}));
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (id_beats.size() > 0) begin
                    b = id_beats.pop_front();
                    i_func      <= b.func;
                    i_data_byte <= b.data;
                    i_nonce_in  <= b.nonce;
                    i_last_byte <= b.last;
                    i_valid     <= 1'b1;
                    gap_left = $urandom_range(0, sender_gap_max);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result beats and draw receiver stalls
    int stall_left = 0;
    int long_hold_left = 0;
    always @(posedge i_clk) begin
        t_cid_result want;
        t_cid_result got;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_out_byte, o_byte_pos, o_end_flag, o_status};
                if (codec_results.size() == 0) begin
                    $display("%0t: unexpected result beat: byte %h pos %0d end %b status %0d",
                             $time, got.out_byte, got.pos, got.last, got.status);
                    mismatch_count++;
                end else begin
                    want = codec_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected byte %h pos %0d end %b status %0d,%s",
                                 $time, want.out_byte, want.pos, want.last, want.status,
                                 $sformatf(" actual byte %h pos %0d end %b status %0d",
                                           got.out_byte, got.pos, got.last, got.status));
                        mismatch_count++;
                    end
                end
                stall_left = $urandom_range(0, stall_max);
            end
            if (long_hold_req) begin
                long_hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("cid_fragment_whitening_codec_unit: mismatch");
            $finish;
        end
    end

    // queue the beats of one identifier; fill < 0 means random plaintext
    task automatic add_identifier(input logic func, input int n, input logic [7:0] idx,
                                  input logic [7:0] tot, input logic [7:0] dlen,
                                  input logic [7:0] nonce, input int fill);
        t_cid_beat b;
        logic [7:0] plain;
        logic [cfwc_pkg::POS_W-1:0] kp;
        for (int p = 0; p < n; p++) begin
            plain = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (p == 5)
                plain = idx;
            else if (p == 6)
                plain = tot;
            else if (p == 7)
                plain = dlen;
            kp = (p > 31) ? cfwc_pkg::POS_MAX : p[cfwc_pkg::POS_W-1:0];
            b.func  = (p == 0) ? func : 1'($urandom);
            b.nonce = (p == 0 && func == FUNC_ENCODE) ? nonce : 8'($urandom);
            if (func == FUNC_ENCODE)
                b.data = plain;
            else if (p == 0)
                b.data = nonce ^ marker_model;
            else
                b.data = plain ^ whitening_pad(nonce, kp);
            b.last = (p == n - 1);
            id_beats.push_back(b);
        end
    endtask

    task automatic add_random_identifier();
        logic func;
        int n;
        int kind;
        logic [7:0] tot;
        logic [7:0] idx;
        logic [7:0] dlen;
        func = 1'($urandom);
        n = $urandom_range((func == FUNC_ENCODE) ? 9 : 8, 20);
        kind = $urandom_range(0, 9);
        tot = 8'($urandom_range(1, 255));
        idx = 8'($urandom_range(0, tot - 1));
        dlen = 8'($urandom_range(0, n - 8));
        case (kind)
            7: begin
                tot = 8'($urandom);
                idx = 8'($urandom);
            end
            8: dlen = 8'($urandom_range(n - 8, 255));
            9: begin
                n = $urandom_range(1, 40);
                tot = 8'($urandom);
                idx = 8'($urandom);
                dlen = 8'($urandom);
            end
            default: ;
        endcase
        add_identifier(func, n, idx, tot, dlen, 8'($urandom), -1);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (id_beats.size() != 0 || i_valid || codec_results.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_marker(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        marker_model = value;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] marker, input int gap_max,
                             input int rx_stall_max, input int n_beats, input bit hold);
        int queued;
        write_marker(marker);
        sender_gap_max = gap_max;
        stall_max = rx_stall_max;
        long_hold_req = hold;
        queued = 0;
        while (queued < n_beats) begin
            queued -= id_beats.size();
            add_random_identifier();
            queued += id_beats.size();
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zeroed payload, minimal lengths, single byte, short decode
        sender_gap_max = 3;
        stall_max = 3;
        add_identifier(FUNC_ENCODE, 9, 8'h00, 8'h01, 8'h00, 8'hFF, 8'hFF);
        add_identifier(FUNC_DECODE, 8, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'h00);
        add_identifier(FUNC_ENCODE, 1, 8'h00, 8'h00, 8'h00, 8'h5A, 0);
        add_identifier(FUNC_DECODE, 7, 8'h00, 8'h01, 8'h00, 8'hA5, -1);
        wait_drained();

        run_phase(8'hFF, 8, 8, 290, 1'b0);
        // back-pressure: the receiver holds off while the sender streams
        run_phase(8'($urandom_range(1, 254)), 0, 0, 290, 1'b1);
        run_phase(8'h00, 0, 0, 145, 1'b0);
        run_phase(8'h00, 8, 0, 145, 1'b0);
        run_phase(8'($urandom), 0, 8, 290, 1'b0);

        if (mismatch_count == 0 && codec_results.size() == 0)
            $display("cid_fragment_whitening_codec_unit: match");
        else
            $display("cid_fragment_whitening_codec_unit: mismatch");
        $finish;
    end

endmodule

### cid_fragment_whitening_codec_unit.f
src/cfwc_pkg.sv
src/cfwc_ctrl.sv
src/cfwc_dpath.sv
src/cid_fragment_whitening_codec_unit.sv
tb/tb_cid_fragment_whitening_codec_unit.sv
